// ===== src/flash_erase_span_planner_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Erase span planner assertion macros
// Concurrent assertion wrappers shared by the planner RTL.
// ----------------------------------------------------------------------------
`ifndef FLASH_ERASE_SPAN_PLANNER_UNIT_MACROS_SVH
`define FLASH_ERASE_SPAN_PLANNER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is asserted.
`define FESP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define FESP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FESP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FESP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/fesp_pkg.sv =====
// ----------------------------------------------------------------------------
// Erase span planner package
// Widths, erase opcodes, result codes and size selection helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fesp_pkg;

  localparam int ADDR_BITS = 24;
  localparam int SPAN_W    = ADDR_BITS + 1;   // addresses up to and including 2^ADDR_BITS
  localparam int SUM_W     = ADDR_BITS + 2;   // address plus size, with rounding headroom
  localparam int SIZE_W    = 25;
  localparam int CAP_W     = 25;

  localparam int LOG4K  = 12;
  localparam int LOG32K = 15;
  localparam int LOG64K = 16;

  localparam logic [SPAN_W-1:0] SZ4K  = SPAN_W'(4096);
  localparam logic [SPAN_W-1:0] SZ32K = SPAN_W'(32 * 1024);
  localparam logic [SPAN_W-1:0] SZ64K = SPAN_W'(64 * 1024);
  localparam logic [SPAN_W-1:0] SPACE = SPAN_W'(1) << ADDR_BITS;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1048576);

  localparam logic [7:0] OPC_ERASE64 = 8'hD8;
  localparam logic [7:0] OPC_ERASE32 = 8'h52;
  localparam logic [7:0] OPC_ERASE4  = 8'h20;
  localparam logic [7:0] OPC_NONE    = 8'h00;

  typedef enum logic {
    OPER_START  = 1'b0,
    OPER_RESULT = 1'b1
  } oper_e;

  typedef enum logic [1:0] {
    KIND_ISSUE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAIL  = 2'd2,
    KIND_UNEXP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_4K   = 2'd1,
    PEND_32K  = 2'd2,
    PEND_64K  = 2'd3
  } pend_e;

  typedef struct packed {
    oper_e                 operation;
    logic [ADDR_BITS-1:0]  span_address;
    logic [SIZE_W-1:0]     span_size;
    logic                  command_ok;
  } item_t;

  typedef struct packed {
    logic [SPAN_W-1:0] cursor;
    logic [SPAN_W-1:0] span_end;
    logic              active;
    pend_e             pending;
  } state_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           opcode;
    logic [ADDR_BITS-1:0] address;
  } result_t;

  // Largest erase that fits at the cursor given the bytes left in the span.
  function automatic pend_e pick_size(logic [SPAN_W-1:0] cur, logic [SPAN_W-1:0] lim);
    logic [SPAN_W-1:0] remain;
    remain = lim - cur;
    if (cur[LOG64K-1:0] == '0 && remain >= SZ64K) begin
      return PEND_64K;
    end else if (cur[LOG32K-1:0] == '0 && remain >= SZ32K) begin
      return PEND_32K;
    end
    return PEND_4K;
  endfunction

  function automatic logic [7:0] opcode_of(pend_e p);
    logic [7:0] opc;
    case (p)
      PEND_64K: opc = OPC_ERASE64;
      PEND_32K: opc = OPC_ERASE32;
      default:  opc = OPC_ERASE4;
    endcase
    return opc;
  endfunction

  function automatic logic [SPAN_W-1:0] bytes_of(pend_e p);
    logic [SPAN_W-1:0] n;
    case (p)
      PEND_64K: n = SZ64K;
      PEND_32K: n = SZ32K;
      default:  n = SZ4K;
    endcase
    return n;
  endfunction

endpackage

// ===== src/fesp_step.sv =====
// ----------------------------------------------------------------------------
// Erase span planner step logic
// Next planner state and result word for one input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fesp_step (
  input  fesp_pkg::state_t                 state_i,
  input  logic [fesp_pkg::CAP_W-1:0]       capacity_i,
  input  fesp_pkg::item_t                  item_i,
  output fesp_pkg::state_t                 state_o,
  output fesp_pkg::result_t                result_o
);
  import fesp_pkg::*;

  logic [SUM_W-1:0]  sum_raw;
  logic [SUM_W-1:0]  cap_w;
  logic [SUM_W-1:0]  addr_w;
  logic              clip;
  logic              beyond;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  rounded;
  logic [SPAN_W-1:0] end_w;
  logic [SPAN_W-1:0] start_w;
  logic [SPAN_W-1:0] next_cur;
  pend_e             pick_start;
  pend_e             pick_next;

  assign addr_w  = SUM_W'(item_i.span_address);
  assign cap_w   = SUM_W'(capacity_i);
  assign sum_raw = addr_w + SUM_W'(item_i.span_size);
  assign clip    = (capacity_i != '0) && (sum_raw > cap_w);
  assign beyond  = addr_w >= cap_w;
  assign total   = clip ? cap_w : sum_raw;
  // round the end up to a sector boundary, then cap at the address space
  assign rounded = (total + SUM_W'(SZ4K - SPAN_W'(1))) & ~SUM_W'(SZ4K - SPAN_W'(1));
  assign end_w   = (rounded > SUM_W'(SPACE)) ? SPACE : rounded[SPAN_W-1:0];
  assign start_w = SPAN_W'(item_i.span_address) & ~(SZ4K - SPAN_W'(1));

  assign next_cur   = state_i.cursor + bytes_of(state_i.pending);
  assign pick_start = pick_size(start_w, end_w);
  assign pick_next  = pick_size(next_cur, state_i.span_end);

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KIND_UNEXP, opcode: OPC_NONE, address: '0};
    if (item_i.operation == OPER_START) begin
      if (state_i.active) begin
        result_o.kind = KIND_UNEXP;
      end else if (clip && beyond) begin
        result_o.kind = KIND_FAIL;
      end else if (start_w >= end_w) begin
        result_o.kind = KIND_DONE;
      end else begin
        state_o.cursor   = start_w;
        state_o.span_end = end_w;
        state_o.active   = 1'b1;
        state_o.pending  = pick_start;
        result_o.kind    = KIND_ISSUE;
        result_o.opcode  = opcode_of(pick_start);
        result_o.address = start_w[ADDR_BITS-1:0];
      end
    end else if (!state_i.active || state_i.pending == PEND_NONE) begin
      result_o.kind = KIND_UNEXP;
    end else if (item_i.command_ok) begin
      state_o.cursor = next_cur;
      if (next_cur >= state_i.span_end) begin
        state_o.active  = 1'b0;
        state_o.pending = PEND_NONE;
        result_o.kind   = KIND_DONE;
      end else begin
        state_o.pending  = pick_next;
        result_o.kind    = KIND_ISSUE;
        result_o.opcode  = opcode_of(pick_next);
        result_o.address = next_cur[ADDR_BITS-1:0];
      end
    end else if (state_i.pending == PEND_32K) begin
      // retry the same block with a sector erase
      state_o.pending  = PEND_4K;
      result_o.kind    = KIND_ISSUE;
      result_o.opcode  = OPC_ERASE4;
      result_o.address = state_i.cursor[ADDR_BITS-1:0];
    end else begin
      state_o.active  = 1'b0;
      state_o.pending = PEND_NONE;
      result_o.kind   = KIND_FAIL;
    end
  end

endmodule

// ===== src/flash_erase_span_planner_unit.sv =====
// Pipeline: a word is held in the input register, and its result in the result register.
// Throughput: one word per cycle unless out_stall_i holds the result; the span state updates
//   in the same cycle as the result register, so each word sees the state left by the word before it.
// Reset: rst_ni clears the span state, both valid flags and restores the capacity
//   register to 1 MiB; no clearing pass, ready for words right after reset.
// ----------------------------------------------------------------------------
// Erase span planner
// Clips and aligns an erase span and walks it with 64K/32K/4K erase commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_erase_span_planner_unit_macros.svh"

module flash_erase_span_planner_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fesp_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic [fesp_pkg::ADDR_BITS-1:0]    span_address_i,
  input  logic [fesp_pkg::SIZE_W-1:0]       span_size_i,
  input  logic                              command_ok_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        result_kind_o,
  output logic [7:0]                        erase_opcode_o,
  output logic [fesp_pkg::ADDR_BITS-1:0]    erase_address_o
);
  import fesp_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             in_valid_q;
  logic             in_valid_d;
  item_t            in_item_q;
  state_t           state_q;
  state_t           state_d;
  logic             out_valid_q;
  logic             out_valid_d;
  result_t          res_q;
  result_t          res_d;
  logic             adv;
  logic             fire;
  logic             load_in;

  fesp_step u_step (
    .state_i    (state_q),
    .capacity_i (cap_q),
    .item_i     (in_item_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  assign adv         = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && adv;
  assign in_stall_o  = in_valid_q && !adv;
  assign load_in     = in_valid_i && !in_stall_o;
  assign in_valid_d  = load_in || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{cursor: '0, span_end: '0, active: 1'b0, pending: PEND_NONE};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_item_q <= '{operation:    oper_e'(operation_i),
                     span_address: span_address_i,
                     span_size:    span_size_i,
                     command_ok:   command_ok_i};
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_kind_o   = res_q.kind;
  assign erase_opcode_o  = res_q.opcode;
  assign erase_address_o = res_q.address;
  assign out_valid_o     = out_valid_q;

  `FESP_ASSERT(a_issue_has_pending, clk_i, rst_ni, (out_valid_o && result_kind_o == KIND_ISSUE) |-> (state_q.active && state_q.pending != PEND_NONE), "issued erase without outstanding command")
  `FESP_ASSERT(a_cursor_in_span, clk_i, rst_ni, state_q.active |-> (state_q.cursor < state_q.span_end), "cursor outside active span")
  `FESP_ASSERT(a_hold_state_on_stall, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(state_q), "span state moved while result stalled")
  `FESP_ASSERT_ALWAYS(a_idle_no_pending, clk_i, !state_q.active |-> (state_q.pending == PEND_NONE), "command pending while idle")

endmodule

// ===== dv/flash_erase_span_planner_unit_test.sv =====
// ----------------------------------------------------------------------------
// Erase span planner testbench
// Drives start and command-result words into the planner under random idle
// and stall, tracks span clipping, alignment and erase size choice in a
// scoreboard, and checks every result word in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flash_erase_span_planner_unit_test;
  import fesp_pkg::*;

  localparam int QUIET_LIMIT      = 2000;
  localparam int WORDS_PER_PHASE  = 230;
  localparam logic [SUM_W-1:0] SECTOR_MASK = ~SUM_W'(4095);

  class erase_plan_tracker;
    logic [CAP_W-1:0]  capacity;
    logic [SPAN_W-1:0] cursor;
    logic [SPAN_W-1:0] span_end;
    bit                busy;
    pend_e             pending;
    result_t           planned_q[$];
    int                mismatches;

    function new();
      capacity   = CAP_RESET;
      cursor     = '0;
      span_end   = '0;
      busy       = 1'b0;
      pending    = PEND_NONE;
      mismatches = 0;
    endfunction

    // Pick the largest erase that is aligned at the cursor and fits what is left.
    function result_t next_erase();
      logic [SPAN_W-1:0] left;
      result_t r;
      left      = span_end - cursor;
      r.kind    = KIND_ISSUE;
      r.address = cursor[ADDR_BITS-1:0];
      if (cursor % SZ64K == 0 && left >= SZ64K) begin
        pending  = PEND_64K;
        r.opcode = OPC_ERASE64;
      end else if (cursor % SZ32K == 0 && left >= SZ32K) begin
        pending  = PEND_32K;
        r.opcode = OPC_ERASE32;
      end else begin
        pending  = PEND_4K;
        r.opcode = OPC_ERASE4;
      end
      return r;
    endfunction

    function result_t plan_word(item_t w);
      logic [SUM_W-1:0] addr;
      logic [SUM_W-1:0] len;
      logic [SUM_W-1:0] first;
      logic [SUM_W-1:0] last;
      result_t r;
      r.kind    = KIND_UNEXP;
      r.opcode  = OPC_NONE;
      r.address = '0;
      if (w.operation == OPER_START) begin
        if (busy) return r;
        addr = SUM_W'(w.span_address);
        len  = SUM_W'(w.span_size);
        if (capacity != '0 && addr + len > SUM_W'(capacity)) begin
          if (addr >= SUM_W'(capacity)) begin
            r.kind = KIND_FAIL;
            return r;
          end
          len = SUM_W'(capacity) - addr;
        end
        first = addr & SECTOR_MASK;
        last  = (addr + len + SUM_W'(4095)) & SECTOR_MASK;
        if (last > SUM_W'(SPACE)) last = SUM_W'(SPACE);
        if (first >= last) begin
          r.kind = KIND_DONE;
          return r;
        end
        cursor   = SPAN_W'(first);
        span_end = SPAN_W'(last);
        busy     = 1'b1;
        return next_erase();
      end
      if (!busy || pending == PEND_NONE) return r;
      if (w.command_ok) begin
        case (pending)
          PEND_64K: cursor = cursor + SZ64K;
          PEND_32K: cursor = cursor + SZ32K;
          default:  cursor = cursor + SZ4K;
        endcase
        if (cursor >= span_end) begin
          busy    = 1'b0;
          pending = PEND_NONE;
          r.kind  = KIND_DONE;
          return r;
        end
        return next_erase();
      end
      // a failed 32K erase retries the same address as a sector erase
      if (pending == PEND_32K) begin
        pending   = PEND_4K;
        r.kind    = KIND_ISSUE;
        r.opcode  = OPC_ERASE4;
        r.address = cursor[ADDR_BITS-1:0];
        return r;
      end
      busy    = 1'b0;
      pending = PEND_NONE;
      r.kind  = KIND_FAIL;
      return r;
    endfunction

    function void note_input(item_t w);
      planned_q.push_back(plan_word(w));
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] opc,
                               logic [ADDR_BITS-1:0] addr);
      result_t want;
      if (planned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word with nothing expected: kind %0d opcode %h addr %h",
                   kind, opc, addr);
        return;
      end
      want = planned_q.pop_front();
      if (kind !== want.kind || opc !== want.opcode || addr !== want.address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp kind %0d opcode %h addr %h, got kind %0d opcode %h addr %h",
                   want.kind, want.opcode, want.address, kind, opc, addr);
      end
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic                  operation_i     = 1'b0;
  logic [ADDR_BITS-1:0]  span_address_i  = '0;
  logic [SIZE_W-1:0]     span_size_i     = '0;
  logic                  command_ok_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [1:0]            result_kind_o;
  logic [7:0]            erase_opcode_o;
  logic [ADDR_BITS-1:0]  erase_address_o;

  erase_plan_tracker sb;
  bit                calm = 1'b0;
  int                words_sent = 0;
  int                quiet_cycles = 0;

  flash_erase_span_planner_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 21);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(result_kind_o, erase_opcode_o, erase_address_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  function automatic item_t word_of(oper_e op, logic [ADDR_BITS-1:0] addr,
                                    logic [SIZE_W-1:0] len, logic ok);
    item_t w;
    w.operation    = op;
    w.span_address = addr;
    w.span_size    = len;
    w.command_ok   = ok;
    return w;
  endfunction

  // Mostly well-formed traffic: answer the outstanding erase while a span is
  // active, open a new span while idle, with some noise mixed in.
  function automatic item_t random_word();
    item_t w;
    logic [SPAN_W-1:0] limit;
    int pick;
    w = word_of(OPER_START, ADDR_BITS'($urandom), SIZE_W'($urandom), 1'($urandom));
    pick = $urandom_range(0, 99);
    if (sb.busy) begin
      if (pick < 93) begin
        w.operation  = OPER_RESULT;
        w.command_ok = ($urandom_range(0, 99) < 88);
      end
      return w;
    end
    if (pick < 8) begin
      w.operation = OPER_RESULT;
      return w;
    end
    if (pick < 13) return w;
    limit = (sb.capacity == '0 || sb.capacity > SPACE) ? SPACE : SPAN_W'(sb.capacity);
    if (pick < 20 && limit < SPACE) begin
      w.span_address = ADDR_BITS'($urandom_range(int'(limit), int'(SPACE) - 1));
      return w;
    end
    w.span_address = ADDR_BITS'($urandom_range(0, int'(limit) - 1));
    case ($urandom_range(0, 3))
      0:       w.span_address[15:0] = '0;
      1:       w.span_address[14:0] = '0;
      2:       w.span_address[11:0] = '0;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       w.span_size = '0;
      1, 2:    w.span_size = SIZE_W'($urandom_range(1, 8)) << 15;
      3:       w.span_size = SIZE_W'($urandom_range(0, 4 << 20));
      4:       w.span_size = SIZE_W'(limit - SPAN_W'(w.span_address));
      default: w.span_size = SIZE_W'($urandom_range(0, 200000));
    endcase
    return w;
  endfunction

  task automatic send_word(input item_t w);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= w.operation;
    span_address_i <= w.span_address;
    span_size_i    <= w.span_size;
    command_ok_i   <= w.command_ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(w);
    words_sent++;
  endtask

  // Hold off input until every expected word is back, then write capacity.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.planned_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps[6];
    sb = new();
    phase_caps[0] = '0;
    phase_caps[1] = CAP_W'(SPACE);
    phase_caps[2] = CAP_W'(4096);
    phase_caps[3] = CAP_W'('h12345);
    phase_caps[4] = CAP_W'($urandom_range(1, 1 << 24));
    phase_caps[5] = CAP_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle result, empty span, unaligned zero size, beyond capacity
    send_word(word_of(OPER_RESULT, '0, '0, 1'b1));
    send_word(word_of(OPER_START, '0, '0, 1'b0));
    send_word(word_of(OPER_START, ADDR_BITS'('h123), '0, 1'b0));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b1));
    send_word(word_of(OPER_START, ADDR_BITS'('h100000), SIZE_W'(1), 1'b0));
    // clipped at capacity, start while busy
    send_word(word_of(OPER_START, ADDR_BITS'('hFF000), '1, 1'b0));
    send_word(word_of(OPER_START, '0, SIZE_W'(4096), 1'b1));
    send_word(word_of(OPER_RESULT, '1, '1, 1'b1));
    // 64K, 32K failing back to 4K, then a failed sector erase
    send_word(word_of(OPER_START, '0, SIZE_W'('h18000), 1'b0));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b1));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b0));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b1));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b0));
    // failed 64K erase
    send_word(word_of(OPER_START, '0, SIZE_W'('h10000), 1'b0));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b0));
    // no clipping, end limited to the address space
    write_capacity('0);
    send_word(word_of(OPER_START, '1, '1, 1'b0));
    send_word(word_of(OPER_RESULT, '0, '0, 1'b1));

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        calm = (words_sent >= 500 && words_sent < 750);
        send_word(random_word());
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.planned_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.planned_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
